// File: rtl/core/hjd_pkg.sv
// Shared types and constants for the headset jack and hook detector.
package hjd_pkg;

  // Counter width default and configuration register width
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned CFG_IDX_W      = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_PRE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_POST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOOK_DEB    = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0] SETTLE_PRE_RST  = 16'd500;
  localparam logic [CFG_W-1:0] SETTLE_POST_RST = 16'd200;
  localparam logic [CFG_W-1:0] HOOK_DEB_RST    = 16'd100;

  // Jack kind codes
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_MIC    = 2'd1;
  localparam logic [1:0] KIND_NO_MIC = 2'd2;

  // Key event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  typedef struct packed {
    logic jack_level;
    logic mic_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] jack_kind;
    logic       bias_on;
    logic       key_held;
    logic [1:0] key_event;
    logic       kind_changed;
  } out_item_t;

  // Requests from jack detection to the hook logic for one item
  typedef struct packed {
    logic hen_wr;    // write hook enable
    logic hen_val;
    logic skip_wr;   // write skip-next flag
    logic skip_val;
    logic drop_key;  // drop a held key on removal
  } det_ctrl_t;

endpackage

// File: rtl/core/hjd_detect.sv
// Jack edge handling and the insertion/removal detection sequencer.
module hjd_detect #(
  parameter int unsigned COUNT_BITS = hjd_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     jack_i,
  input  logic                     mic_i,
  input  logic [hjd_pkg::CFG_W-1:0] settle_pre_i,
  input  logic [hjd_pkg::CFG_W-1:0] settle_post_i,
  output logic [1:0]               kind_o,
  output logic                     kind_changed_o,
  output logic                     bias_o,
  output hjd_pkg::det_ctrl_t       ctrl_o
);

  localparam int unsigned W = (COUNT_BITS > hjd_pkg::CFG_W) ? COUNT_BITS : hjd_pkg::CFG_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  localparam logic [1:0] PH_IDLE        = 2'd0;
  localparam logic [1:0] PH_CHECK       = 2'd1;
  localparam logic [1:0] PH_WAIT_BIAS   = 2'd2;
  localparam logic [1:0] PH_WAIT_SAMPLE = 2'd3;

  logic [1:0]            kind_q, kind_d;
  logic [1:0]            phase_q, phase_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic                  red_q, red_d;
  logic                  bias_q, bias_d;
  logic                  prev_jack_q;
  logic                  jack_edge;
  logic [W-1:0]          limit;
  logic                  wait_done;
  hjd_pkg::det_ctrl_t    ctrl;

  // Saturating wait counter against the limit of the current phase
  assign cnt_inc   = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + CNT_ONE;
  assign limit     = (phase_q == PH_WAIT_BIAS) ? W'(settle_pre_i) : W'(settle_post_i);
  assign wait_done = (W'(cnt_inc) >= limit) || (cnt_inc == CNT_MAX);
  assign jack_edge = (jack_i != prev_jack_q) && (jack_i != (kind_q != hjd_pkg::KIND_NONE));

  // Next state for one item
  always_comb begin
    kind_d  = kind_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    red_d   = red_q;
    bias_d  = bias_q;
    ctrl    = '0;

    if (jack_edge) begin
      ctrl.hen_wr  = 1'b1;
      ctrl.hen_val = 1'b0;
      if (phase_d == PH_IDLE) begin
        phase_d = PH_CHECK;
      end else begin
        red_d = 1'b1;
      end
    end

    if (phase_d == PH_IDLE && red_d) begin
      red_d   = 1'b0;
      phase_d = PH_CHECK;
    end

    unique case (phase_d)
      PH_CHECK: begin
        if (!jack_i) begin
          bias_d      = 1'b0;
          ctrl.hen_wr = 1'b1;
          if (kind_q != hjd_pkg::KIND_NONE) begin
            ctrl.skip_wr  = 1'b1;
            ctrl.skip_val = 1'b1;
            kind_d        = hjd_pkg::KIND_NONE;
            ctrl.hen_val  = 1'b0;
            ctrl.drop_key = 1'b1;
          end else begin
            ctrl.hen_val = 1'b1;
          end
          phase_d = PH_IDLE;
        end else begin
          cnt_d   = '0;
          phase_d = PH_WAIT_BIAS;
        end
      end
      PH_WAIT_BIAS: begin
        cnt_d = cnt_inc;
        if (wait_done) begin
          bias_d  = 1'b1;
          cnt_d   = '0;
          phase_d = PH_WAIT_SAMPLE;
        end
      end
      PH_WAIT_SAMPLE: begin
        cnt_d = cnt_inc;
        if (wait_done) begin
          ctrl.skip_wr  = 1'b1;
          ctrl.skip_val = !mic_i;
          ctrl.hen_wr   = 1'b1;
          ctrl.hen_val  = 1'b1;
          if (kind_q == hjd_pkg::KIND_NONE) begin
            if (jack_i) begin
              if (!mic_i) begin
                kind_d = hjd_pkg::KIND_NO_MIC;
                bias_d = 1'b0;
              end else begin
                kind_d = hjd_pkg::KIND_MIC;
              end
            end else begin
              bias_d = 1'b0;
            end
          end
          cnt_d   = '0;
          phase_d = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  // Advance state when the item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= hjd_pkg::KIND_NONE;
      phase_q     <= PH_CHECK;
      cnt_q       <= '0;
      red_q       <= 1'b0;
      bias_q      <= 1'b0;
      prev_jack_q <= 1'b0;
    end else if (adv_i) begin
      kind_q      <= kind_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      red_q       <= red_d;
      bias_q      <= bias_d;
      prev_jack_q <= jack_i;
    end
  end

  assign kind_o         = kind_d;
  assign kind_changed_o = (kind_d != kind_q);
  assign bias_o         = bias_d;
  assign ctrl_o         = ctrl;

endmodule

// File: rtl/core/hjd_hook.sv
// Hook line debounce timer and media key state.
module hjd_hook #(
  parameter int unsigned COUNT_BITS = hjd_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     mic_i,
  input  logic [1:0]               kind_i,
  input  hjd_pkg::det_ctrl_t       ctrl_i,
  input  logic [hjd_pkg::CFG_W-1:0] debounce_i,
  output logic                     key_held_o,
  output logic [1:0]               key_event_o
);

  localparam int unsigned W = (COUNT_BITS > hjd_pkg::CFG_W) ? COUNT_BITS : hjd_pkg::CFG_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic                  run_q, run_d;
  logic                  hen_q, hen_d;
  logic                  skip_q, skip_d;
  logic                  pressed_q, pressed_d;
  logic                  prev_mic_q;
  logic                  expired;
  logic [1:0]            event_d;

  // Saturating debounce counter
  assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + CNT_ONE;
  assign expired = (W'(cnt_inc) >= W'(debounce_i)) || (cnt_inc == CNT_MAX);

  // Apply detection requests, then timer expiry, then hook edge
  always_comb begin
    cnt_d     = cnt_q;
    run_d     = run_q;
    hen_d     = ctrl_i.hen_wr ? ctrl_i.hen_val : hen_q;
    skip_d    = ctrl_i.skip_wr ? ctrl_i.skip_val : skip_q;
    pressed_d = pressed_q;
    event_d   = hjd_pkg::EV_NONE;

    if (ctrl_i.drop_key && pressed_q) begin
      pressed_d = 1'b0;
      event_d   = hjd_pkg::EV_RELEASE;
    end

    if (run_q) begin
      cnt_d = cnt_inc;
      if (expired) begin
        run_d = 1'b0;
        if (kind_i == hjd_pkg::KIND_MIC && hen_d) begin
          if (mic_i) begin
            if (skip_d) begin
              skip_d = 1'b0;
            end else if (pressed_d) begin
              pressed_d = 1'b0;
              event_d   = hjd_pkg::EV_RELEASE;
            end
          end else if (!skip_d && !pressed_d) begin
            pressed_d = 1'b1;
            event_d   = hjd_pkg::EV_PRESS;
          end
        end
      end
    end

    if (mic_i != prev_mic_q && hen_d) begin
      cnt_d = '0;
      run_d = 1'b1;
    end
  end

  // Advance state when the item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      run_q      <= 1'b0;
      hen_q      <= 1'b0;
      skip_q     <= 1'b0;
      pressed_q  <= 1'b0;
      prev_mic_q <= 1'b1;
    end else if (adv_i) begin
      cnt_q      <= cnt_d;
      run_q      <= run_d;
      hen_q      <= hen_d;
      skip_q     <= skip_d;
      pressed_q  <= pressed_d;
      prev_mic_q <= mic_i;
    end
  end

  assign key_held_o  = pressed_d;
  assign key_event_o = event_d;

endmodule

// File: rtl/core/headset_jack_and_hook_detector_core.sv
// Top level of the headset jack and hook detector: handshakes, config and result register.
//
//  Channel  Direction  Handshake                Payload
//  in       input      in_valid_i / in_stall_o   in_data_i  (jack and mic levels)
//  out      output     out_valid_o / out_stall_i out_data_o (kind, bias, key state)
//  cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled; an item moves from the input
// register to the output register when the result register is free or being drained.
// The rate is set by the single pass through the detection and hook logic.
// Reset clears the counters and flags, starts detection in its check phase and returns the config to defaults.
// A stalled output holds its item; the input register stalls only while it holds an
// item that cannot move on, so a waiting result blocks the input once both registers
// are full.
module headset_jack_and_hook_detector_core #(
  parameter int unsigned COUNT_BITS = hjd_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hjd_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hjd_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [hjd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hjd_pkg::CFG_W-1:0]     cfg_data_i
);

  logic                      in_valid_q;
  hjd_pkg::in_item_t         in_q;
  logic                      out_valid_q;
  hjd_pkg::out_item_t        out_q, out_d;
  logic                      adv;
  logic [hjd_pkg::CFG_W-1:0] settle_pre_q, settle_post_q, hook_deb_q;
  logic [1:0]                kind_w;
  logic                      kind_changed_w;
  logic                      bias_w;
  logic                      key_held_w;
  logic [1:0]                key_event_w;
  hjd_pkg::det_ctrl_t        det_ctrl;

  // Move the held item on when the result register is free or being drained
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_pre_q  <= hjd_pkg::SETTLE_PRE_RST;
      settle_post_q <= hjd_pkg::SETTLE_POST_RST;
      hook_deb_q    <= hjd_pkg::HOOK_DEB_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hjd_pkg::CFG_SETTLE_PRE:  settle_pre_q  <= cfg_data_i;
        hjd_pkg::CFG_SETTLE_POST: settle_post_q <= cfg_data_i;
        hjd_pkg::CFG_HOOK_DEB:    hook_deb_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  hjd_detect #(
    .COUNT_BITS(COUNT_BITS)
  ) u_detect (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .jack_i        (in_q.jack_level),
    .mic_i         (in_q.mic_level),
    .settle_pre_i  (settle_pre_q),
    .settle_post_i (settle_post_q),
    .kind_o        (kind_w),
    .kind_changed_o(kind_changed_w),
    .bias_o        (bias_w),
    .ctrl_o        (det_ctrl)
  );

  hjd_hook #(
    .COUNT_BITS(COUNT_BITS)
  ) u_hook (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .mic_i      (in_q.mic_level),
    .kind_i     (kind_w),
    .ctrl_i     (det_ctrl),
    .debounce_i (hook_deb_q),
    .key_held_o (key_held_w),
    .key_event_o(key_event_w)
  );

  // Assemble the result item
  always_comb begin
    out_d.jack_kind    = kind_w;
    out_d.bias_on      = bias_w;
    out_d.key_held     = key_held_w;
    out_d.key_event    = key_event_w;
    out_d.kind_changed = kind_changed_w;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // A held item must stall the input while the result register is blocked
  a_stall_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input not stalled while result register blocked");

  // A processed item always lands in the result register
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("processed item lost");

  // A held key only exists with a headset that has a mic
  a_held_needs_mic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.key_held |-> out_data_o.jack_kind == hjd_pkg::KIND_MIC)
    else $error("key held without mic headset");

  // A press report leaves the key held
  a_press_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.key_event == hjd_pkg::EV_PRESS |-> out_data_o.key_held)
    else $error("press reported without key held");
`endif

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the headset jack and hook detector core.
`timescale 1ns / 1ps

module tb_top;
  import hjd_pkg::*;

  localparam int CNT_W       = COUNT_BITS_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DIR_ROWS    = 25;

  // Detection progress as the block steps through it
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CHECK,
    PH_WAIT_BIAS,
    PH_WAIT_SAMPLE
  } det_phase_e;

  // One item to send, with an optional fixed result
  typedef struct packed {
    in_item_t  tick;
    logic      pinned;
    out_item_t want;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Timing registers as last written
  logic [CFG_W-1:0] pre_bias_ticks  = SETTLE_PRE_RST;
  logic [CFG_W-1:0] post_bias_ticks = SETTLE_POST_RST;
  logic [CFG_W-1:0] debounce_ticks  = HOOK_DEB_RST;

  // Detector state as predicted
  logic [1:0]       kind_q       = KIND_NONE;
  det_phase_e       phase_q      = PH_CHECK;
  logic [CNT_W-1:0] settle_cnt   = '0;
  logic             redetect_q   = 1'b0;
  logic [CNT_W-1:0] debounce_cnt = '0;
  logic             debounce_run = 1'b0;
  logic             hook_on      = 1'b0;
  logic             skip_release = 1'b0;
  logic             key_down     = 1'b0;
  logic             bias_q       = 1'b0;
  logic             jack_last    = 1'b0;
  logic             mic_last     = 1'b1;

  out_item_t status_q [$];
  stim_t     tick_q [$];
  int        fault_cnt   = 0;
  int        res_seen    = 0;
  int        idle_cycles = 0;
  int        burst_left  = 0;
  bit        hold_req    = 1'b0;
  bit        hold_done   = 1'b0;

  // Plug, hook press and removal sequences; fixed results on the clear-cut rows
  stim_t script [0:DIR_ROWS-1] = '{
    '{'{1'b0, 1'b1}, 1'b1, '{KIND_NONE, 1'b0, 1'b0, EV_NONE, 1'b0}},
    '{'{1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b1, 1'b0}, 1'b1, '{KIND_MIC, 1'b1, 1'b1, EV_PRESS, 1'b0}},
    '{'{1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 1'b1}, 1'b1, '{KIND_MIC, 1'b1, 1'b0, EV_RELEASE, 1'b0}},
    '{'{1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b1, 1'b0}, 1'b1, '{KIND_MIC, 1'b1, 1'b1, EV_PRESS, 1'b0}},
    '{'{1'b0, 1'b0}, 1'b1, '{KIND_NONE, 1'b0, 1'b0, EV_RELEASE, 1'b1}},
    '{'{1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b1, 1'b0}, 1'b1, '{KIND_NO_MIC, 1'b0, 1'b0, EV_NONE, 1'b1}},
    '{'{1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b0, 1'b1}, 1'b1, '{KIND_NONE, 1'b0, 1'b0, EV_NONE, 1'b1}},
    '{'{1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 1'b1}, 1'b0, '0}
  };

  headset_jack_and_hook_detector_core #(
    .COUNT_BITS(CNT_W)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Advance the predicted detector by one item and return its status
  function automatic out_item_t next_jack_status(in_item_t it);
    out_item_t  res;
    logic [1:0] kind_was;
    logic [1:0] ev;
    logic       plugged;
    kind_was = kind_q;
    ev       = EV_NONE;
    plugged  = (kind_q != KIND_NONE);

    // jack edge away from the stored presence starts or queues a run
    if (it.jack_level != jack_last && it.jack_level != plugged) begin
      hook_on = 1'b0;
      if (phase_q == PH_IDLE) phase_q = PH_CHECK;
      else redetect_q = 1'b1;
    end
    if (phase_q == PH_IDLE && redetect_q) begin
      redetect_q = 1'b0;
      phase_q    = PH_CHECK;
    end

    case (phase_q)
      PH_CHECK: begin
        if (!it.jack_level) begin
          bias_q = 1'b0;
          if (kind_q != KIND_NONE) begin
            skip_release = 1'b1;
            kind_q       = KIND_NONE;
            hook_on      = 1'b0;
            if (key_down) begin
              key_down = 1'b0;
              ev       = EV_RELEASE;
            end
          end else begin
            hook_on = 1'b1;
          end
          phase_q = PH_IDLE;
        end else begin
          settle_cnt = '0;
          phase_q    = PH_WAIT_BIAS;
        end
      end
      PH_WAIT_BIAS: begin
        settle_cnt = sat_inc(settle_cnt);
        if (settle_cnt >= pre_bias_ticks || settle_cnt == '1) begin
          bias_q     = 1'b1;
          settle_cnt = '0;
          phase_q    = PH_WAIT_SAMPLE;
        end
      end
      PH_WAIT_SAMPLE: begin
        settle_cnt = sat_inc(settle_cnt);
        if (settle_cnt >= post_bias_ticks || settle_cnt == '1) begin
          skip_release = !it.mic_level;
          hook_on      = 1'b1;
          if (kind_q == KIND_NONE) begin
            if (!it.jack_level) begin
              bias_q = 1'b0;
            end else if (!it.mic_level) begin
              kind_q = KIND_NO_MIC;
              bias_q = 1'b0;
            end else begin
              kind_q = KIND_MIC;
            end
          end
          settle_cnt = '0;
          phase_q    = PH_IDLE;
        end
      end
      default: ;
    endcase

    // debounce expiry, then a hook edge restarts the timer
    if (debounce_run) begin
      debounce_cnt = sat_inc(debounce_cnt);
      if (debounce_cnt >= debounce_ticks || debounce_cnt == '1) begin
        debounce_run = 1'b0;
        if (kind_q == KIND_MIC && hook_on) begin
          if (it.mic_level) begin
            if (skip_release) begin
              skip_release = 1'b0;
            end else if (key_down) begin
              key_down = 1'b0;
              ev       = EV_RELEASE;
            end
          end else if (!skip_release && !key_down) begin
            key_down = 1'b1;
            ev       = EV_PRESS;
          end
        end
      end
    end
    if (it.mic_level != mic_last && hook_on) begin
      debounce_cnt = '0;
      debounce_run = 1'b1;
    end

    jack_last        = it.jack_level;
    mic_last         = it.mic_level;
    res.jack_kind    = kind_q;
    res.bias_on      = bias_q;
    res.key_held     = key_down;
    res.key_event    = ev;
    res.kind_changed = (kind_q != kind_was);
    return res;
  endfunction

  function automatic string show_status(out_item_t s);
    return $sformatf("kind=%0d bias=%0b held=%0b ev=%0d chg=%0b",
                     s.jack_kind, s.bias_on, s.key_held, s.key_event, s.kind_changed);
  endfunction

  task automatic report_fault(string why);
    if (fault_cnt < 10) $display("[%0t] MISMATCH: %s", $realtime, why);
    fault_cnt++;
  endtask

  // Write all three timing registers while the block is idle
  task automatic load_timing(logic [CFG_W-1:0] pre, logic [CFG_W-1:0] post,
                             logic [CFG_W-1:0] deb);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SETTLE_PRE;
    cfg_data <= pre;
    @(posedge clk);
    cfg_idx  <= CFG_SETTLE_POST;
    cfg_data <= post;
    @(posedge clk);
    cfg_idx  <= CFG_HOOK_DEB;
    cfg_data <= deb;
    @(posedge clk);
    cfg_we          <= 1'b0;
    pre_bias_ticks  = pre;
    post_bias_ticks = post;
    debounce_ticks  = deb;
  endtask

  // Offer one item in bursts with random gaps, hold it until taken
  task automatic offer(stim_t e);
    int        gap;
    out_item_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data  <= e.tick;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    res = next_jack_status(e.tick);
    status_q.push_back(e.pinned ? e.want : res);
  endtask

  // Send the queued items, then let every result drain
  task automatic run_ticks();
    while (tick_q.size() != 0) offer(tick_q.pop_front());
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic void push_ticks(logic j, logic m, int n);
    stim_t e;
    e      = '0;
    e.tick = '{j, m};
    repeat (n) tick_q.push_back(e);
  endfunction

  // Keep hold lengths modest when the registers are large
  function automatic int span(int x);
    return (x > 60) ? 60 : x;
  endfunction

  // Fill the queue with plug sessions, broken sequences and noise
  task automatic build_random(int budget);
    int   pick;
    int   presses;
    logic four_pole;
    while (tick_q.size() < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // full plug cycle with hook activity
        four_pole = ($urandom_range(0, 3) != 0);
        push_ticks(1'b1, four_pole,
                   span(pre_bias_ticks + post_bias_ticks) + $urandom_range(3, 7));
        if (four_pole) begin
          presses = $urandom_range(0, 4);
          repeat (presses) begin
            push_ticks(1'b1, 1'b0, span(debounce_ticks) + $urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0) push_ticks(1'b1, 1'b1, $urandom_range(1, 2));
            push_ticks(1'b1, 1'b1, span(debounce_ticks) + $urandom_range(1, 4));
          end
        end else begin
          push_ticks(1'b1, 1'($urandom_range(0, 1)), $urandom_range(2, 10));
        end
        push_ticks(1'b0, 1'($urandom_range(0, 1)), $urandom_range(2, 8));
      end else if (pick < 8) begin
        // removal or bounce in the middle of detection
        push_ticks(1'b1, 1'($urandom_range(0, 1)),
                   $urandom_range(1, span(pre_bias_ticks + post_bias_ticks) + 2));
        push_ticks(1'b0, 1'b1, $urandom_range(1, 3));
        if ($urandom_range(0, 1) == 1) push_ticks(1'b1, 1'b1, $urandom_range(1, 3));
      end else begin
        repeat ($urandom_range(4, 24))
          push_ticks(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom_range(1, 3));
      end
    end
    while (tick_q.size() > budget) void'(tick_q.pop_back());
  endtask

  // Receiver: stall patterns in segments, one long hold-off on request
  initial begin
    int seg;
    int mode;
    int k;
    k = 0;
    forever begin
      if (hold_req && !hold_done) begin
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(20, 120);
        repeat (seg) begin
          @(posedge clk);
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 9) < 3);
            2:       out_stall <= (k % 3 == 0);
            default: out_stall <= ($urandom_range(0, 9) < 7);
          endcase
          k++;
        end
      end
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    string     bad;
    if (rst_n && out_valid && !out_stall) begin
      res_seen++;
      if (status_q.size() == 0) begin
        report_fault($sformatf("result %0d with nothing pending: %s",
                               res_seen, show_status(out_data)));
      end else begin
        want = status_q.pop_front();
        bad  = "";
        if (out_data.jack_kind !== want.jack_kind) bad = {bad, " jack_kind"};
        if (out_data.bias_on !== want.bias_on) bad = {bad, " bias_on"};
        if (out_data.key_held !== want.key_held) bad = {bad, " key_held"};
        if (out_data.key_event !== want.key_event) bad = {bad, " key_event"};
        if (out_data.kind_changed !== want.kind_changed) bad = {bad, " kind_changed"};
        if (bad != "")
          report_fault($sformatf("result %0d,%s: expected %s, got %s", res_seen, bad,
                                 show_status(want), show_status(out_data)));
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset, directed rows, then random phases over several timing settings
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_timing(16'd1, 16'd0, 16'd2);
    for (int i = 0; i < DIR_ROWS; i++) tick_q.push_back(script[i]);
    run_ticks();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          load_timing(16'd0, 16'd0, 16'd0);
          build_random(250);
        end
        1: begin
          load_timing(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 12)),
                      CFG_W'($urandom_range(1, 12)));
          build_random(400);
          hold_req = 1'b1;
        end
        2: begin
          load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
          build_random(80);
        end
        3: begin
          load_timing(CFG_W'($urandom_range(0, 30)), CFG_W'($urandom_range(0, 30)),
                      CFG_W'($urandom_range(0, 40)));
          build_random(400);
        end
        default: begin
          load_timing(CFG_W'($urandom_range(2, 16)), CFG_W'($urandom_range(2, 16)),
                      CFG_W'($urandom_range(2, 16)));
          build_random(450);
        end
      endcase
      run_ticks();
    end

    repeat (8) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/hjd_pkg.sv
rtl/core/hjd_detect.sv
rtl/core/hjd_hook.sv
rtl/core/headset_jack_and_hook_detector_core.sv
test/tb_top.sv
